>>> rtl/tlpc_pkg.sv
`timescale 1ns / 1ps
package tlpc_pkg;

   localparam int MAX_VERTICES = 1024;
   localparam int MAX_LOOPS    = 16;
   localparam int COORD_BITS   = 20;

   localparam int VIDX_BITS = $clog2(MAX_VERTICES);
   localparam int VCNT_BITS = $clog2(MAX_VERTICES + 1);
   localparam int LIDX_BITS = (MAX_LOOPS > 1) ? $clog2(MAX_LOOPS) : 1;
   localparam int LCNT_BITS = $clog2(MAX_LOOPS + 1);
   localparam int DIFF_BITS = COORD_BITS + 1;
   localparam int PROD_BITS = 2 * DIFF_BITS;

   // drain length after the last vertex read, so the accumulator is updated before it is read
   localparam int PIPE_DEPTH = 4;
   localparam int PIPE_BITS  = $clog2(PIPE_DEPTH);

   localparam logic [1:0] REQ_CLEAR  = 2'd0;
   localparam logic [1:0] REQ_APPEND = 2'd1;
   localparam logic [1:0] REQ_QUERY  = 2'd2;

   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_STORE_FULL = 2'd1;
   localparam logic [1:0] STATUS_LOOPS_FULL = 2'd2;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   // tag that travels with a vertex read
   typedef struct packed {
      logic valid;
      logic first;   // previous vertex of the loop, loads only
      logic last;    // last edge of the loop
   } vtag_type;

   typedef struct packed {
      logic valid;
      logic toggle;
      logic last;
   } edge_res_type;

endpackage

>>> rtl/trim_loop_point_classifier.sv
`timescale 1ns / 1ps
// Point classifier against closed polygon loops (even-odd crossing rule).
// Input channel req_*: clear all loops, append a vertex (req_closes_loop ends
// the current loop), or query a point. Every request returns exactly one
// response on rsp_*: rsp_trimmed is 1 for a query point outside some closed
// loop, rsp_status flags an append dropped because the vertex store or the
// loop table is full.
// Clear and append are done in the cycle they are accepted; the response is registered and shows up
// the cycle after the transaction.
// A query reads the vertex store once per cycle through its single read port:
// for each closed loop, its last vertex and then every vertex, then it drains
// the edge pipeline before the response. One request is in service at a time;
// req_ready is low while a query runs.
// When the receiver stalls, the response holds in the output register and
// req_ready stays low until it is taken.
// Reset empties the loop table and the vertex count; no clearing pass runs.
module trim_loop_point_classifier
   import tlpc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_type,
   input  logic signed [COORD_BITS-1:0] req_point_x,
   input  logic signed [COORD_BITS-1:0] req_point_y,
   input  logic                  req_closes_loop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_trimmed,
   output logic [1:0]            rsp_status
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_WALK   = 2'd1;
   localparam logic [1:0] ST_DRAIN  = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0]           state_ff, state_in;
   logic [VCNT_BITS-1:0] vcount_ff, vcount_in;
   logic [LCNT_BITS-1:0] lcount_ff, lcount_in;
   logic [VCNT_BITS-1:0] loop_end_ff [MAX_LOOPS];

   logic [LCNT_BITS-1:0] loop_idx_ff, loop_idx_in;
   logic [VCNT_BITS-1:0] start_ff, start_in;
   logic [VIDX_BITS-1:0] addr_ff, addr_in;
   logic                 first_ff, first_in;
   logic [PIPE_BITS-1:0] drain_ff, drain_in;
   coord_type            qx_ff, qy_ff;

   logic par_ff, par_in, trim_ff, trim_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_trimmed_ff, rsp_trimmed_in;
   logic [1:0] rsp_status_ff, rsp_status_in;
   logic       rsp_free;

   logic                 accept;
   logic                 wr_en, end_wr;
   logic                 rd_en;
   logic [VIDX_BITS-1:0] rd_addr;
   logic [VCNT_BITS-1:0] cur_end, cur_last;
   vtag_type             tag_in, tag_ff;
   coord_type            rd_u, rd_v;
   edge_res_type         eres;
   logic                 par_next;

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && rsp_free;
   assign accept    = req_valid && req_ready;

   assign cur_end  = loop_end_ff[loop_idx_ff[LIDX_BITS-1:0]];
   assign cur_last = cur_end - 1'b1;

   always_comb begin
      state_in       = state_ff;
      vcount_in      = vcount_ff;
      lcount_in      = lcount_ff;
      loop_idx_in    = loop_idx_ff;
      start_in       = start_ff;
      addr_in        = addr_ff;
      first_in       = first_ff;
      drain_in       = drain_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_trimmed_in = rsp_trimmed_ff;
      rsp_status_in  = rsp_status_ff;
      wr_en          = 1'b0;
      end_wr         = 1'b0;
      rd_en          = 1'b0;
      rd_addr        = addr_ff;
      tag_in         = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_trimmed_in = 1'b0;
               rsp_status_in  = STATUS_OK;
               rsp_valid_in   = 1'b1;
               case (req_type)
                  REQ_CLEAR: begin
                     vcount_in = '0;
                     lcount_in = '0;
                  end
                  REQ_APPEND: begin
                     if (vcount_ff == VCNT_BITS'(MAX_VERTICES)) begin
                        rsp_status_in = STATUS_STORE_FULL;
                     end else if (req_closes_loop &&
                                  lcount_ff == LCNT_BITS'(MAX_LOOPS)) begin
                        rsp_status_in = STATUS_LOOPS_FULL;
                     end else begin
                        wr_en     = 1'b1;
                        vcount_in = vcount_ff + 1'b1;
                        if (req_closes_loop) begin
                           end_wr    = 1'b1;
                           lcount_in = lcount_ff + 1'b1;
                        end
                     end
                  end
                  REQ_QUERY: begin
                     rsp_valid_in = rsp_valid_ff && !rsp_ready;
                     loop_idx_in  = '0;
                     start_in     = '0;
                     first_in     = 1'b1;
                     state_in     = (lcount_ff == '0) ? ST_FINISH : ST_WALK;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_WALK: begin
            rd_en        = 1'b1;
            tag_in.valid = 1'b1;
            if (first_ff) begin
               rd_addr      = cur_last[VIDX_BITS-1:0];
               tag_in.first = 1'b1;
               first_in     = 1'b0;
               addr_in      = start_ff[VIDX_BITS-1:0];
            end else begin
               rd_addr = addr_ff;
               if ({1'b0, addr_ff} == cur_last) begin
                  tag_in.last = 1'b1;
                  loop_idx_in = loop_idx_ff + 1'b1;
                  start_in    = cur_end;
                  first_in    = 1'b1;
                  if (loop_idx_ff + 1'b1 == lcount_ff) begin
                     drain_in = '0;
                     state_in = ST_DRAIN;
                  end
               end else begin
                  addr_in = addr_ff + 1'b1;
               end
            end
         end
         ST_DRAIN: begin
            if (drain_ff == PIPE_BITS'(PIPE_DEPTH - 1)) begin
               state_in = ST_FINISH;
            end else begin
               drain_in = drain_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_trimmed_in = trim_ff;
               rsp_status_in  = STATUS_OK;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // parity per loop; a loop left with even parity marks the point trimmed
   assign par_next = par_ff ^ eres.toggle;

   always_comb begin
      par_in  = par_ff;
      trim_in = trim_ff;
      if (accept) begin
         par_in  = 1'b0;
         trim_in = 1'b0;
      end else if (eres.valid) begin
         if (eres.last) begin
            par_in = 1'b0;
            if (!par_next) begin
               trim_in = 1'b1;
            end
         end else begin
            par_in = par_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         vcount_ff    <= '0;
         lcount_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         tag_ff       <= '0;
         first_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vcount_ff    <= vcount_in;
         lcount_ff    <= lcount_in;
         rsp_valid_ff <= rsp_valid_in;
         tag_ff       <= tag_in;
         first_ff     <= first_in;
      end
   end

   always_ff @(posedge clock) begin
      loop_idx_ff    <= loop_idx_in;
      start_ff       <= start_in;
      addr_ff        <= addr_in;
      drain_ff       <= drain_in;
      par_ff         <= par_in;
      trim_ff        <= trim_in;
      rsp_trimmed_ff <= rsp_trimmed_in;
      rsp_status_ff  <= rsp_status_in;
      if (accept) begin
         qx_ff <= req_point_x;
         qy_ff <= req_point_y;
      end
      if (end_wr) begin
         loop_end_ff[lcount_ff[LIDX_BITS-1:0]] <= vcount_ff + 1'b1;
      end
   end

   tlpc_vertex_ram u_vram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (vcount_ff[VIDX_BITS-1:0]),
      .wr_u    (req_point_x),
      .wr_v    (req_point_y),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_u    (rd_u),
      .rd_v    (rd_v)
   );

   tlpc_edge_unit u_edge (
      .clock  (clock),
      .reset  (reset),
      .qx     (qx_ff),
      .qy     (qy_ff),
      .in_tag (tag_ff),
      .in_u   (rd_u),
      .in_v   (rd_v),
      .res    (eres)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_trimmed = rsp_trimmed_ff;
   assign rsp_status  = rsp_status_ff;

endmodule

>>> rtl/tlpc_vertex_ram.sv
`timescale 1ns / 1ps
module tlpc_vertex_ram
   import tlpc_pkg::*;
(
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [VIDX_BITS-1:0] wr_addr,
   input  coord_type            wr_u,
   input  coord_type            wr_v,
   input  logic                 rd_en,
   input  logic [VIDX_BITS-1:0] rd_addr,
   output coord_type            rd_u,
   output coord_type            rd_v
);

   logic [2*COORD_BITS-1:0] mem [MAX_VERTICES];
   logic [2*COORD_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_u, wr_v};
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_u = coord_type'(rd_data_ff[2*COORD_BITS-1:COORD_BITS]);
   assign rd_v = coord_type'(rd_data_ff[COORD_BITS-1:0]);

endmodule

>>> rtl/tlpc_edge_unit.sv
`timescale 1ns / 1ps
module tlpc_edge_unit
   import tlpc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  coord_type    qx,
   input  coord_type    qy,
   input  vtag_type     in_tag,
   input  coord_type    in_u,
   input  coord_type    in_v,
   output edge_res_type res
);

   coord_type prev_u_ff, prev_v_ff;

   // stage A: differences
   logic                        a_valid_ff, a_last_ff, a_span_ff;
   logic                        a_span_in;
   logic signed [DIFF_BITS-1:0] a_dxp_ff, a_dy_ff, a_dxj_ff, a_dyp_ff;

   // stage B: products
   logic                        b_valid_ff, b_last_ff, b_span_ff, b_pos_ff, b_neg_ff;
   logic signed [PROD_BITS-1:0] b_p1_ff, b_p2_ff;

   logic res_valid_ff, res_toggle_ff, res_last_ff;
   logic toggle_in;

   // y in [min(yi,yj), max(yi,yj)), current vertex is i, previous is j
   assign a_span_in = ((in_v <= qy) && (qy < prev_v_ff)) ||
                      ((prev_v_ff <= qy) && (qy < in_v));

   always_ff @(posedge clock) begin
      if (in_tag.valid) begin
         prev_u_ff <= in_u;
         prev_v_ff <= in_v;
      end
      a_last_ff <= in_tag.last;
      a_span_ff <= a_span_in;
      a_dxp_ff  <= DIFF_BITS'(qx) - DIFF_BITS'(in_u);
      a_dy_ff   <= DIFF_BITS'(prev_v_ff) - DIFF_BITS'(in_v);
      a_dxj_ff  <= DIFF_BITS'(prev_u_ff) - DIFF_BITS'(in_u);
      a_dyp_ff  <= DIFF_BITS'(qy) - DIFF_BITS'(in_v);

      b_last_ff <= a_last_ff;
      b_span_ff <= a_span_ff;
      b_pos_ff  <= !a_dy_ff[DIFF_BITS-1] && (a_dy_ff != '0);
      b_neg_ff  <= a_dy_ff[DIFF_BITS-1];
      b_p1_ff   <= PROD_BITS'(a_dxp_ff) * PROD_BITS'(a_dy_ff);
      b_p2_ff   <= PROD_BITS'(a_dxj_ff) * PROD_BITS'(a_dyp_ff);

      res_toggle_ff <= toggle_in;
      res_last_ff   <= b_last_ff;
   end

   assign toggle_in = b_span_ff &&
                      ((b_pos_ff && (b_p1_ff < b_p2_ff)) ||
                       (b_neg_ff && (b_p1_ff > b_p2_ff)));

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         res_valid_ff <= 1'b0;
      end else begin
         a_valid_ff   <= in_tag.valid && !in_tag.first;
         b_valid_ff   <= a_valid_ff;
         res_valid_ff <= b_valid_ff;
      end
   end

   assign res = {res_valid_ff, res_toggle_ff, res_last_ff};

endmodule
